// ===== hw/rtl/half_step_bolt_sequencer_core_defines.svh =====
// ----------------------------------------------------------------------------
// Half-step bolt sequencer assertion macros
// Shared concurrent assertion forms used by the sequencer top level.
// ----------------------------------------------------------------------------
`ifndef HALF_STEP_BOLT_SEQUENCER_CORE_DEFINES_SVH
`define HALF_STEP_BOLT_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HSB_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HSB_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/hsb_pkg.sv =====
// ----------------------------------------------------------------------------
// Half-step bolt sequencer package
// Command and register codes, shared structs and the half-step coil table.
// ----------------------------------------------------------------------------
package hsb_pkg;

  localparam int STEP_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 2;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_LOCK   = 3'd1;
  localparam logic [2:0] CMD_UNLOCK = 3'd2;
  localparam logic [2:0] CMD_REOPEN = 3'd3;
  localparam logic [2:0] CMD_JOG    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_STEPS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_DIR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_DELAY = 2'd2;

  localparam logic [15:0] LOCK_STEPS_RST = 16'd1024;
  localparam logic [15:0] STEP_DELAY_RST = 16'd1000;

  typedef struct packed {
    logic [2:0]  command;
    logic        jog_open;
    logic [15:0] jog_steps;
  } hsb_item_t;

  typedef struct packed {
    logic [15:0] lock_steps;
    logic        lock_dir_reversed;
    logic [15:0] step_delay;
  } hsb_cfg_t;

  typedef struct packed {
    logic [3:0] coils;
    logic [2:0] phase;
    logic       busy_res;
    logic       done_res;
    logic       rejected;
  } hsb_res_t;

  // Half-step pattern: bit0 is coil 1.
  function automatic logic [3:0] hsb_coil(input logic [2:0] ph);
    logic [3:0] c;
    unique case (ph)
      3'd0: c = 4'h1;
      3'd1: c = 4'h3;
      3'd2: c = 4'h2;
      3'd3: c = 4'h6;
      3'd4: c = 4'h4;
      3'd5: c = 4'hC;
      3'd6: c = 4'h8;
      3'd7: c = 4'h9;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/hsb_in_reg.sv =====
// ----------------------------------------------------------------------------
// Half-step bolt sequencer input register
// Captures one item and holds it until the sequencer takes it.
// ----------------------------------------------------------------------------
module hsb_in_reg
  import hsb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  hsb_item_t in_item,
  input  logic      take,
  output logic      item_vld,
  output hsb_item_t item
);

  logic      vld_r, vld_nxt;
  hsb_item_t item_r;
  logic      load;

  assign in_stall = vld_r && !take;
  assign load     = in_valid && !in_stall;
  assign vld_nxt  = load || (vld_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

// ===== hw/rtl/hsb_seq.sv =====
// ----------------------------------------------------------------------------
// Half-step bolt sequencer state and step logic
// Holds the move state and computes one item's update and result.
// ----------------------------------------------------------------------------
module hsb_seq
  import hsb_pkg::*;
#(
  parameter int STEP_BITS = STEP_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  hsb_item_t item,
  input  hsb_cfg_t  cfg,
  output hsb_res_t  res
);

  logic [2:0]           phase_r, phase_nxt;
  logic [3:0]           coil_r, coil_nxt;
  logic [STEP_BITS-1:0] steps_r, steps_nxt;
  logic                 dir_r, dir_nxt;
  logic                 pend_r, pend_nxt;
  logic [15:0]          dly_r, dly_nxt;
  logic                 run_r, run_nxt;

  logic [31:0]          lock_w, reopen_w, jog_w;
  logic [STEP_BITS-1:0] steps_a, steps_b;
  logic                 dir_a, dir_b, pend_a, pend_b;
  logic [15:0]          dly_dec;
  logic                 adv, start, done, rej, up;

  assign lock_w   = {16'b0, cfg.lock_steps};
  assign reopen_w = {19'b0, cfg.lock_steps[15:3]};
  assign jog_w    = {16'b0, item.jog_steps};
  assign dly_dec  = (dly_r != 16'd0) ? dly_r - 16'd1 : 16'd0;

  always_comb begin
    phase_nxt = phase_r;
    coil_nxt  = coil_r;
    steps_nxt = steps_r;
    dir_nxt   = dir_r;
    pend_nxt  = pend_r;
    dly_nxt   = dly_r;
    run_nxt   = run_r;
    steps_a   = steps_r;
    dir_a     = dir_r;
    pend_a    = pend_r;
    steps_b   = steps_r;
    dir_b     = dir_r;
    pend_b    = pend_r;
    adv       = 1'b0;
    start     = 1'b0;
    done      = 1'b0;
    rej       = 1'b0;
    up        = 1'b0;

    if (fire) begin
      if (run_r) begin
        if (item.command != CMD_TICK) begin
          rej = 1'b1;
        end else begin
          dly_nxt = dly_dec;
          adv     = (dly_dec == 16'd0);
        end
      end else begin
        unique case (item.command)
          CMD_LOCK: begin
            start = 1'b1; dir_a = 1'b0; pend_a = 1'b0;
            steps_a = lock_w[STEP_BITS-1:0];
          end
          CMD_UNLOCK: begin
            start = 1'b1; dir_a = 1'b1; pend_a = 1'b0;
            steps_a = lock_w[STEP_BITS-1:0];
          end
          CMD_REOPEN: begin
            start = 1'b1; dir_a = 1'b0; pend_a = 1'b1;
            steps_a = reopen_w[STEP_BITS-1:0];
          end
          CMD_JOG: begin
            start = 1'b1; dir_a = item.jog_open; pend_a = 1'b0;
            steps_a = jog_w[STEP_BITS-1:0];
          end
          default: start = 1'b0;
        endcase
        if (start) begin
          run_nxt = 1'b1;
          dly_nxt = 16'd0;
          adv     = 1'b1;
        end
      end
    end

    if (adv) begin
      steps_b = steps_a;
      dir_b   = dir_a;
      pend_b  = pend_a;
      // Lock-side segment of a reopen is over: turn around for the full stroke.
      if (steps_a == '0 && pend_a) begin
        pend_b  = 1'b0;
        dir_b   = 1'b1;
        steps_b = lock_w[STEP_BITS-1:0];
      end
      dir_nxt  = dir_b;
      pend_nxt = pend_b;
      if (steps_b != '0) begin
        up        = !(dir_b ^ cfg.lock_dir_reversed);
        phase_nxt = up ? phase_r + 3'd1 : phase_r - 3'd1;
        coil_nxt  = hsb_coil(phase_nxt);
        steps_nxt = steps_b - {{(STEP_BITS-1){1'b0}}, 1'b1};
        dly_nxt   = cfg.step_delay;
      end else begin
        steps_nxt = steps_b;
        coil_nxt  = 4'h0;
        run_nxt   = 1'b0;
        dly_nxt   = 16'd0;
        done      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 3'd0;
      coil_r  <= 4'h0;
      steps_r <= '0;
      dir_r   <= 1'b0;
      pend_r  <= 1'b0;
      dly_r   <= 16'd0;
      run_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      coil_r  <= coil_nxt;
      steps_r <= steps_nxt;
      dir_r   <= dir_nxt;
      pend_r  <= pend_nxt;
      dly_r   <= dly_nxt;
      run_r   <= run_nxt;
    end
  end

  assign res.coils    = coil_nxt;
  assign res.phase    = phase_nxt;
  assign res.busy_res = run_nxt;
  assign res.done_res = done;
  assign res.rejected = rej;

endmodule

// ===== hw/rtl/half_step_bolt_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// Half-step bolt sequencer core
// Four-coil stepper driver with the eight-phase half-step pattern, driven by
// tick and command items, one result item per input item.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------
//  in_      | input     | in_valid / in_stall | command, jog_open, jog_steps
//  out_     | output    | out_valid/out_stall | coils, phase, busy, done, rej
//  cfg_     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One item per clock sustained while the output is not stalled; each item
//  waits in the input register, and its result is loaded into the result
//  register when the sequencer takes it and is offered from then on. The
//  move state update is one short pass through the step logic between those
//  registers.
//  Reset is synchronous and active low; registers come up at 1024 lock steps,
//  normal direction and a 1000-tick step delay. No clearing pass.
//  A stalled result holds in the result register; the input register then
//  fills and in_stall rises, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "half_step_bolt_sequencer_core_defines.svh"

module half_step_bolt_sequencer_core
  import hsb_pkg::*;
#(
  parameter int STEP_BITS = STEP_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input items
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_command,
  input  logic                 in_jog_open,
  input  logic [15:0]          in_jog_steps,
  // result items
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           out_coils,
  output logic [2:0]           out_phase,
  output logic                 out_busy_res,
  output logic                 out_done_res,
  output logic                 out_rejected,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  hsb_item_t in_item, item;
  hsb_cfg_t  cfg_r, cfg_nxt;
  hsb_res_t  res, res_r;
  logic      item_vld, fire;
  logic      out_vld_r, out_vld_nxt;

  assign in_item.command   = in_command;
  assign in_item.jog_open  = in_jog_open;
  assign in_item.jog_steps = in_jog_steps;

  // Process the held item whenever the result register is free or draining.
  assign fire = item_vld && (!out_vld_r || !out_stall);

  hsb_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (fire),
    .item_vld (item_vld),
    .item     (item)
  );

  hsb_seq #(
    .STEP_BITS (STEP_BITS)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .cfg   (cfg_r),
    .res   (res)
  );

  // Register file: always ready; writes beyond the list are dropped.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOCK_STEPS: cfg_nxt.lock_steps        = cfg_data;
        CFG_LOCK_DIR:   cfg_nxt.lock_dir_reversed = cfg_data[0];
        CFG_STEP_DELAY: cfg_nxt.step_delay        = cfg_data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lock_steps        <= LOCK_STEPS_RST;
      cfg_r.lock_dir_reversed <= 1'b0;
      cfg_r.step_delay        <= STEP_DELAY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Result register: load on fire, drop once taken, hold while stalled.
  always_comb begin
    priority if (fire) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_coils    = res_r.coils;
  assign out_phase    = res_r.phase;
  assign out_busy_res = res_r.busy_res;
  assign out_done_res = res_r.done_res;
  assign out_rejected = res_r.rejected;

  // A finished move leaves the coils off and the block idle.
  `HSB_ASSERT_NOW(a_done_idle, out_valid && out_done_res, !out_busy_res && out_coils == 4'h0, "done with coils on or busy")
  // A rejected command only happens during a move, which it leaves running.
  `HSB_ASSERT_NOW(a_rej_busy, out_valid && out_rejected, out_busy_res && !out_done_res, "reject outside a move")
  // The input side stalls only while an item waits in the input register.
  `HSB_ASSERT_NOW(a_stall_full, in_stall, item_vld && !fire, "input stall without held item")
  // A stalled result stays valid.
  `HSB_ASSERT_NEXT(a_res_hold, out_valid && out_stall, out_valid, "result lost under stall")

endmodule
